// ===== rtl/core/idt_pkg.sv =====
// ----------------------------------------------------------------------------
// idt_pkg
// Shared types, constants and codes for the indent/dedent tracker.
// ----------------------------------------------------------------------------
package idt_pkg;

    // Sizing of the indent stack and of a measured width
    localparam int STACK_DEPTH = 32;
    localparam int WIDTH_BITS  = 8;
    localparam int IDX_BITS    = $clog2(STACK_DEPTH);
    localparam int CNT_BITS    = $clog2(STACK_DEPTH + 1);
    localparam int TAB_STOP    = 4;
    localparam int TAB_SHIFT   = $clog2(TAB_STOP);

    // Field widths
    localparam int ACTION_BITS = 2;
    localparam int BYTE_BITS   = 8;
    localparam int LINE_BITS   = 20;
    localparam int KIND_BITS   = 3;

    // Stream packing
    localparam int S_TDATA_BITS = 32;
    localparam int M_TDATA_BITS = 24;

    localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = {WIDTH_BITS{1'b1}};

    // Characters of interest
    localparam logic [BYTE_BITS-1:0] CHAR_TAB  = 8'h09;
    localparam logic [BYTE_BITS-1:0] CHAR_LF   = 8'h0A;
    localparam logic [BYTE_BITS-1:0] CHAR_CR   = 8'h0D;
    localparam logic [BYTE_BITS-1:0] CHAR_SP   = 8'h20;
    localparam logic [BYTE_BITS-1:0] CHAR_HASH = 8'h23;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_NEW_LINE = 2'd0,
        ACT_BYTE     = 2'd1,
        ACT_END      = 2'd2,
        ACT_UNUSED   = 2'd3
    } action_t;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_INDENT   = 3'd0,
        KIND_DEDENT   = 3'd1,
        KIND_MISMATCH = 3'd2,
        KIND_OVERFLOW = 3'd3,
        KIND_END      = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        MODE_MEASURE = 2'd0,
        MODE_COMMENT = 2'd1,
        MODE_BODY    = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_JUDGE,
        ST_POP,
        ST_POP_WAIT,
        ST_POP_CHK,
        ST_MISMATCH,
        ST_END_POP
    } state_t;

    // Request from the sequencer to the stack memory
    typedef struct packed {
        logic                  we;
        logic [IDX_BITS-1:0]   waddr;
        logic [WIDTH_BITS-1:0] wdata;
        logic [IDX_BITS-1:0]   raddr;
    } stk_req_t;

    // Outcome of the shared comparator
    typedef struct packed {
        logic gt;
        logic lt;
        logic eq;
    } cmp_res_t;

endpackage

// ===== rtl/core/indent_dedent_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// indent_dedent_tracker_unit
// Indentation tracker for an offside-rule tokenizer.
// ----------------------------------------------------------------------------
// Input stream: tuser carries the action (new line, source byte, end of
// input); tdata carries the source byte and the line number. Output stream:
// one transfer per token, tuser the token kind, tdata its line number, tlast
// set on the final token caused by one input transfer.
// Timing: bytes that only update the measured width, or are ignored,
// stream at one per cycle while no token burst runs. The first body byte
// of a line moves on to a judge step; each DEDENT passes through pop,
// stack memory read and compare steps in the shared comparator loop, and
// a mismatch adds a mismatch step. End of input emits one DEDENT per level
// above the base, then the end marker. tready is low while a token burst runs.
// Reset leaves one stored level of width zero, measuring mode, and an
// empty output register; the stack memory needs no clearing, since the
// base level is never read from it. A stalled receiver holds the output
// register and halts emitting states until the transfer completes.
// ----------------------------------------------------------------------------
module indent_dedent_tracker_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [idt_pkg::S_TDATA_BITS-1:0] s_axis_tdata,  // byte_req[7:0], line[27:8]
    input  logic [idt_pkg::ACTION_BITS-1:0]  s_axis_tuser,  // action[1:0]
    // Output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [idt_pkg::M_TDATA_BITS-1:0] m_axis_tdata,  // token_line[19:0]
    output logic [idt_pkg::KIND_BITS-1:0]    m_axis_tuser,  // kind[2:0]
    output logic                             m_axis_tlast
);
    import idt_pkg::*;

    state_t                state_reg, state_next;
    mode_t                 mode_reg, mode_next;
    logic [WIDTH_BITS-1:0] width_reg, width_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [WIDTH_BITS-1:0] top_reg, top_next;
    logic [LINE_BITS-1:0]  line_reg, line_next;

    logic                  out_valid_reg, out_valid_next;
    kind_t                 out_kind_reg, out_kind_next;
    logic [LINE_BITS-1:0]  out_line_reg, out_line_next;
    logic                  out_last_reg, out_last_next;

    stk_req_t              stk_req;
    logic [WIDTH_BITS-1:0] stk_rdata;
    cmp_res_t              cmp_res;

    logic                  in_xfer;
    logic                  emit_ok;
    action_t               in_action;
    logic [BYTE_BITS-1:0]  in_byte;
    logic [LINE_BITS-1:0]  in_line;
    logic                  more_pops;
    logic                  mism;

    assign in_action = action_t'(s_axis_tuser);
    assign in_byte   = s_axis_tdata[BYTE_BITS-1:0];
    assign in_line   = s_axis_tdata[BYTE_BITS +: LINE_BITS];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign emit_ok       = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {{(M_TDATA_BITS - LINE_BITS){1'b0}}, out_line_reg};
    assign m_axis_tlast  = out_last_reg;

    idt_stack u_stack (
        .clk   (clk),
        .req   (stk_req),
        .rdata (stk_rdata)
    );

    idt_cmp u_cmp (
        .width (width_reg),
        .top   (top_reg),
        .res   (cmp_res)
    );

    // Pop check: another level above the width, or a final mismatch
    assign more_pops = (count_reg > CNT_BITS'(1)) && cmp_res.lt;
    assign mism      = !more_pops && !cmp_res.eq;

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_MEASURE;
            width_reg     <= '0;
            count_reg     <= CNT_BITS'(1);
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            width_reg     <= width_next;
            count_reg     <= count_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        line_reg     <= line_next;
        out_kind_reg <= out_kind_next;
        out_line_reg <= out_line_next;
        out_last_reg <= out_last_next;
    end

    // Next state, width measurement and token emission
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        width_next     = width_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        line_next      = line_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_kind_next  = out_kind_reg;
        out_line_next  = out_line_reg;
        out_last_next  = out_last_reg;
        stk_req        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    line_next = in_line;
                    case (in_action)
                        ACT_NEW_LINE:
                        begin
                            mode_next  = MODE_MEASURE;
                            width_next = '0;
                        end
                        ACT_BYTE:
                        begin
                            case (mode_reg)
                                MODE_COMMENT:
                                begin
                                    if (in_byte == CHAR_LF)
                                    begin
                                        mode_next  = MODE_MEASURE;
                                        width_next = '0;
                                    end
                                end
                                MODE_MEASURE:
                                begin
                                    case (in_byte)
                                        CHAR_CR:
                                        begin
                                            width_next = width_reg;
                                        end
                                        CHAR_SP:
                                        begin
                                            if (width_reg != WIDTH_MAX)
                                            begin
                                                width_next = width_reg + WIDTH_BITS'(1);
                                            end
                                        end
                                        CHAR_TAB:
                                        begin
                                            // advance to next tab stop, saturating
                                            if (&width_reg[WIDTH_BITS-1:TAB_SHIFT])
                                            begin
                                                width_next = WIDTH_MAX;
                                            end
                                            else
                                            begin
                                                width_next = {
                                                    width_reg[WIDTH_BITS-1:TAB_SHIFT]
                                                        + (WIDTH_BITS - TAB_SHIFT)'(1),
                                                    {TAB_SHIFT{1'b0}}};
                                            end
                                        end
                                        CHAR_LF:
                                        begin
                                            width_next = '0;
                                        end
                                        CHAR_HASH:
                                        begin
                                            mode_next = MODE_COMMENT;
                                        end
                                        default:
                                        begin
                                            mode_next  = MODE_BODY;
                                            state_next = ST_JUDGE;
                                        end
                                    endcase
                                end
                                default:
                                begin
                                    mode_next = mode_reg;
                                end
                            endcase
                        end
                        ACT_END:
                        begin
                            mode_next  = MODE_MEASURE;
                            width_next = '0;
                            state_next = ST_END_POP;
                        end
                        default:
                        begin
                            line_next = line_reg;
                        end
                    endcase
                end
            end

            // Compare the measured width with the current top level
            ST_JUDGE:
            begin
                if (cmp_res.gt)
                begin
                    if (emit_ok)
                    begin
                        out_valid_next = 1'b1;
                        out_line_next  = line_reg;
                        out_last_next  = 1'b1;
                        if (count_reg == CNT_BITS'(STACK_DEPTH))
                        begin
                            out_kind_next = KIND_OVERFLOW;
                        end
                        else
                        begin
                            out_kind_next = KIND_INDENT;
                            stk_req.we    = 1'b1;
                            stk_req.waddr = count_reg[IDX_BITS-1:0];
                            stk_req.wdata = width_reg;
                            count_next    = count_reg + CNT_BITS'(1);
                            top_next      = width_reg;
                        end
                        state_next = ST_IDLE;
                    end
                end
                else if (cmp_res.lt)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            // Drop one level and fetch the one beneath it
            ST_POP:
            begin
                stk_req.raddr = IDX_BITS'(count_reg - CNT_BITS'(2));
                count_next    = count_reg - CNT_BITS'(1);
                state_next    = ST_POP_WAIT;
            end

            // Base level is always zero and never read from memory
            ST_POP_WAIT:
            begin
                top_next   = (count_reg == CNT_BITS'(1)) ? '0 : stk_rdata;
                state_next = ST_POP_CHK;
            end

            // Emit the DEDENT once it is known whether more follows
            ST_POP_CHK:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_DEDENT;
                    out_line_next  = line_reg;
                    out_last_next  = !more_pops && !mism;
                    if (more_pops)
                    begin
                        state_next = ST_POP;
                    end
                    else if (mism)
                    begin
                        state_next = ST_MISMATCH;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_MISMATCH:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_MISMATCH;
                    out_line_next  = line_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            // End of input: one DEDENT per level above the base, then the marker
            ST_END_POP:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    out_line_next  = line_reg;
                    if (count_reg > CNT_BITS'(1))
                    begin
                        out_kind_next = KIND_DEDENT;
                        out_last_next = 1'b0;
                        count_next    = count_reg - CNT_BITS'(1);
                    end
                    else
                    begin
                        out_kind_next = KIND_END;
                        out_last_next = 1'b1;
                        top_next      = '0;
                        state_next    = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/idt_cmp.sv =====
// ----------------------------------------------------------------------------
// idt_cmp
// Shared magnitude comparator: measured width against the stack top.
// ----------------------------------------------------------------------------
module idt_cmp (
    input  logic [idt_pkg::WIDTH_BITS-1:0] width,
    input  logic [idt_pkg::WIDTH_BITS-1:0] top,
    output idt_pkg::cmp_res_t              res
);
    import idt_pkg::*;

    // One compare serves both the judge step and every pop check
    always_comb
    begin
        res.gt = (width > top);
        res.lt = (width < top);
        res.eq = (width == top);
    end

endmodule

// ===== rtl/core/idt_stack.sv =====
// ----------------------------------------------------------------------------
// idt_stack
// Indent level memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module idt_stack (
    input  logic                           clk,
    input  idt_pkg::stk_req_t              req,
    output logic [idt_pkg::WIDTH_BITS-1:0] rdata
);
    import idt_pkg::*;

    logic [WIDTH_BITS-1:0] mem [STACK_DEPTH];

    // Write on push, read the level below on pop
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule
